/* hw/rtl/ascon_permutation_unit_defines.svh */
// Assertion macros shared by the permutation unit's RTL files.
// No dependencies; users pass a label, a property body and a message.
`ifndef ASCON_PERMUTATION_UNIT_DEFINES_SVH
`define ASCON_PERMUTATION_UNIT_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define APU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define APU_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* hw/rtl/ascon_perm_pkg.sv */
// Types and constants for the Ascon-p permutation unit.
// No dependencies; used by the controller, the datapath and the top level.
package ascon_perm_pkg;

   localparam int WordWidth   = 64;
   localparam int WordCount   = 5;
   localparam int CountWidth  = 5;
   localparam int IndexWidth  = 4;
   localparam int TableDepth  = 16;

   // Round constants; an r-round permutation uses the last r entries.
   localparam logic [7:0] RC_TABLE [TableDepth] = '{
      8'h3c, 8'h2d, 8'h1e, 8'h0f, 8'hf0, 8'he1, 8'hd2, 8'hc3,
      8'hb4, 8'ha5, 8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
   };

   typedef logic [WordCount-1:0][WordWidth-1:0] words_type;

   typedef struct packed {
      logic [WordWidth-1:0]  word0_in;
      logic [WordWidth-1:0]  word1_in;
      logic [WordWidth-1:0]  word2_in;
      logic [WordWidth-1:0]  word3_in;
      logic [WordWidth-1:0]  word4_in;
      logic [CountWidth-1:0] round_count;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] word0_out;
      logic [WordWidth-1:0] word1_out;
      logic [WordWidth-1:0] word2_out;
      logic [WordWidth-1:0] word3_out;
      logic [WordWidth-1:0] word4_out;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic finishing;
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } fsm_type;

endpackage

/* hw/rtl/ascon_perm_ctrl.sv */
// Controller for the Ascon-p permutation unit: state machine and result valid.
// Depends on ascon_perm_pkg and ascon_permutation_unit_defines.svh.
`include "ascon_permutation_unit_defines.svh"

module ascon_perm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  ascon_perm_pkg::status_type status,
   output ascon_perm_pkg::cmd_type    cmd
);
   import ascon_perm_pkg::*;

   fsm_type state_ff, state_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free;

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The output register is free when empty or drained in this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (status.finishing) begin
               if (out_free) begin
                  cmd.emit = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A new result fills the register; a taken one empties it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `APU_ASSERT(a_emit_into_free, cmd.emit |-> (!rsp_valid_ff || rsp_ready), "result overwritten")
   `APU_ASSERT(a_busy_after_load, (req_valid && req_ready) |=> !req_ready, "accepted while busy")
   `APU_ASSERT(a_emit_sets_valid, cmd.emit |=> rsp_valid, "emitted result not shown")

endmodule

/* hw/rtl/ascon_perm_dp.sv */
// Datapath for the Ascon-p permutation unit: state, round counters, round logic
// and output register. Depends on ascon_perm_pkg and the defines header.
`include "ascon_permutation_unit_defines.svh"

module ascon_perm_dp #(
   parameter int MAX_ROUNDS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ascon_perm_pkg::req_type    req_data,
   input  ascon_perm_pkg::cmd_type    cmd,
   output ascon_perm_pkg::status_type status,
   output ascon_perm_pkg::rsp_type    rsp_data
);
   import ascon_perm_pkg::*;

   localparam logic [CountWidth-1:0] MaxRounds = CountWidth'(MAX_ROUNDS);
   localparam logic [CountWidth-1:0] Depth     = CountWidth'(TableDepth);

   words_type               state_ff, state_in;
   words_type               round_out;
   logic [CountWidth-1:0]   left_ff, left_in;
   logic [IndexWidth-1:0]   idx_ff, idx_in;
   logic [CountWidth-1:0]   sat_count;
   logic [CountWidth-1:0]   start_idx;
   rsp_type                 out_ff, out_in;

   function automatic logic [WordWidth-1:0] ror64(logic [WordWidth-1:0] v, int k);
      return (v >> k) | (v << (WordWidth - k));
   endfunction

   // One full round: constant addition, S-box layer, linear diffusion.
   function automatic words_type ascon_round(words_type s, logic [IndexWidth-1:0] idx);
      logic [WordWidth-1:0] a0, a1, a2, a3, a4;
      logic [WordWidth-1:0] n0, n1, n2, n3, n4;
      words_type            r;
      a0 = s[0];
      a1 = s[1];
      a2 = s[2] ^ {{(WordWidth-8){1'b0}}, RC_TABLE[idx]};
      a3 = s[3];
      a4 = s[4];
      a0 = a0 ^ a4;
      a4 = a4 ^ a3;
      a2 = a2 ^ a1;
      n0 = ~a0 & a1;
      n1 = ~a1 & a2;
      n2 = ~a2 & a3;
      n3 = ~a3 & a4;
      n4 = ~a4 & a0;
      a0 = a0 ^ n1;
      a1 = a1 ^ n2;
      a2 = a2 ^ n3;
      a3 = a3 ^ n4;
      a4 = a4 ^ n0;
      a1 = a1 ^ a0;
      a0 = a0 ^ a4;
      a3 = a3 ^ a2;
      a2 = ~a2;
      r[0] = a0 ^ ror64(a0, 19) ^ ror64(a0, 28);
      r[1] = a1 ^ ror64(a1, 61) ^ ror64(a1, 39);
      r[2] = a2 ^ ror64(a2, 1) ^ ror64(a2, 6);
      r[3] = a3 ^ ror64(a3, 10) ^ ror64(a3, 17);
      r[4] = a4 ^ ror64(a4, 7) ^ ror64(a4, 41);
      return r;
   endfunction

   // Clamp the requested count and find the first table entry to use.
   assign sat_count = (req_data.round_count > MaxRounds) ? MaxRounds : req_data.round_count;
   assign start_idx = Depth - sat_count;

   assign round_out = ascon_round(state_ff, idx_ff);

   // The last round, or no round at all, completes this cycle.
   assign status.finishing = (left_ff <= CountWidth'(1));

   // Next state, counters and output.
   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      idx_in   = idx_ff;
      out_in   = out_ff;
      if (cmd.load) begin
         state_in = {req_data.word4_in, req_data.word3_in, req_data.word2_in,
                     req_data.word1_in, req_data.word0_in};
         left_in  = sat_count;
         idx_in   = start_idx[IndexWidth-1:0];
      end else if (cmd.step) begin
         state_in = round_out;
         left_in  = left_ff - CountWidth'(1);
         idx_in   = idx_ff + IndexWidth'(1);
      end
      if (cmd.emit) begin
         if (left_ff == '0) begin
            out_in = {state_ff[0], state_ff[1], state_ff[2], state_ff[3], state_ff[4]};
         end else begin
            out_in = {round_out[0], round_out[1], round_out[2], round_out[3], round_out[4]};
         end
      end
   end

   // The round counter is cleared so its status is defined from reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      idx_ff   <= idx_in;
      out_ff   <= out_in;
   end

   assign rsp_data = out_ff;

   `APU_ASSERT(a_step_counts_down, (!reset && cmd.step) |=> (left_ff == $past(left_ff) - CountWidth'(1)), "round count not decremented")
   `APU_ASSERT(a_count_bounded, left_ff <= MaxRounds, "round count beyond limit")
   `APU_ASSERT(a_no_step_when_done, cmd.step |-> (left_ff > CountWidth'(1)), "round past the end")

endmodule

/* hw/rtl/ascon_permutation_unit.sv */
// Channel | Direction | Payload
// req_    | in        | ascon_perm_pkg::req_type: five state words and a round count
// rsp_    | out       | ascon_perm_pkg::rsp_type: five permuted state words
//
// An item with a clamped count of r rounds is loaded in its accept cycle, then takes
// one round per cycle through a single shared round unit; the last round waits until
// the output register is free. A count of zero still passes through the busy state.
// No new item is accepted until its result is in the output register.
// Reset clears the state machine, the round counter and the result valid only.
// A result left untaken holds the last round until the output register frees;
// the next beat is accepted while a finished result waits.
// Depends on ascon_perm_pkg, ascon_perm_ctrl and ascon_perm_dp.
module ascon_permutation_unit #(
   parameter int MAX_ROUNDS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ascon_perm_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ascon_perm_pkg::rsp_type rsp_data
);
   import ascon_perm_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing of load, rounds and result hand-off.
   ascon_perm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // State register, shared round unit and output register.
   ascon_perm_dp #(
      .MAX_ROUNDS (MAX_ROUNDS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* dv/tb_ascon_permutation_unit.sv */
// Self-checking testbench for the Ascon-p permutation unit: random and directed
// state words and round counts, with results checked against an in-bench permutation.
// Depends on ascon_perm_pkg and ascon_permutation_unit.
module tb_ascon_permutation_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ascon_perm_pkg::*;

   localparam int MAX_ROUNDS   = 16;
   localparam int ROUND_SLOTS  = 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 20;

   // The 16 round constants; an r-round permutation uses the last r of them.
   localparam logic [7:0] ROUND_CONST [ROUND_SLOTS] = '{
      8'h3c, 8'h2d, 8'h1e, 8'h0f, 8'hf0, 8'he1, 8'hd2, 8'hc3,
      8'hb4, 8'ha5, 8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
   };

   // Right-rotation pairs of the linear layer, one pair per word.
   localparam int ROT_FIRST  [5] = '{19, 61, 1, 10, 7};
   localparam int ROT_SECOND [5] = '{28, 39, 6, 17, 41};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type perm_pending_q [$];
   rsp_type perm_expect_q [$];

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_armed    = 1'b0;
   int   hold_count    = 0;
   logic req_taken     = 1'b0;
   int   quiet_cycles  = 0;
   int   error_count   = 0;

   ascon_permutation_unit #(
      .MAX_ROUNDS(MAX_ROUNDS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rotr64(logic [63:0] v, int k);
      return (v >> k) | (v << (64 - k));
   endfunction

   // Applies the clamped number of rounds to the five state words.
   function automatic rsp_type predict_perm(req_type item);
      logic [63:0] s [5];
      logic [63:0] n [5];
      int          rounds;
      rsp_type     result;
      s[0] = item.word0_in;
      s[1] = item.word1_in;
      s[2] = item.word2_in;
      s[3] = item.word3_in;
      s[4] = item.word4_in;
      rounds = (item.round_count > MAX_ROUNDS) ? MAX_ROUNDS : int'(item.round_count);
      for (int r = 0; r < rounds; r++) begin
         // Constant addition.
         s[2] ^= 64'(ROUND_CONST[ROUND_SLOTS - rounds + r]);
         // Bitsliced S-box across all 64 columns.
         s[0] ^= s[4];
         s[4] ^= s[3];
         s[2] ^= s[1];
         for (int k = 0; k < 5; k++) n[k] = ~s[k] & s[(k + 1) % 5];
         for (int k = 0; k < 5; k++) s[k] ^= n[(k + 1) % 5];
         s[1] ^= s[0];
         s[0] ^= s[4];
         s[3] ^= s[2];
         s[2] = ~s[2];
         // Linear diffusion.
         for (int k = 0; k < 5; k++) begin
            s[k] = s[k] ^ rotr64(s[k], ROT_FIRST[k]) ^ rotr64(s[k], ROT_SECOND[k]);
         end
      end
      result.word0_out = s[0];
      result.word1_out = s[1];
      result.word2_out = s[2];
      result.word3_out = s[3];
      result.word4_out = s[4];
      return result;
   endfunction

   // Biased word source so that all-zero, all-one and one-hot states show up often.
   function automatic logic [63:0] pick_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 64'h1 << $urandom_range(63);
         3: return ~(64'h1 << $urandom_range(63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type make_req(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                                        logic [63:0] w3, logic [63:0] w4, int count);
      req_type item;
      item.word0_in    = w0;
      item.word1_in    = w1;
      item.word2_in    = w2;
      item.word3_in    = w3;
      item.word4_in    = w4;
      item.round_count = 5'(count);
      return item;
   endfunction

   task automatic flag_error(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // Most counts are legal; about one in ten exercises saturation above the maximum.
   task automatic queue_random(int count);
      int rounds;
      for (int i = 0; i < count; i++) begin
         rounds = ($urandom_range(9) == 0) ? $urandom_range(31, 17) : $urandom_range(16);
         perm_pending_q.push_back(make_req(pick_word(), pick_word(), pick_word(),
                                           pick_word(), pick_word(), rounds));
      end
   endtask

   // Holds the sender back until every queued beat has been answered.
   task automatic wait_drained();
      while (perm_pending_q.size() != 0 || perm_expect_q.size() != 0 || req_valid) begin
         @(posedge clock);
      end
   endtask

   // Request driver: a beat stays on the bus, unchanged, until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (perm_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= perm_pending_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response ready, with one long hold-off once it is armed.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_armed && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predicts on each request beat, checks each response beat, and
   // ends the run if neither channel moves for too long.
   always @(posedge clock) begin : monitor
      rsp_type     expected;
      words_type   got_w;
      words_type   want_w;
      logic        moved;
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         moved     = (req_valid && req_ready) || (rsp_valid && rsp_ready);
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (perm_expect_q.size() == 0) begin
               flag_error("response beat with no expected result waiting");
            end else begin
               expected = perm_expect_q.pop_front();
               got_w    = rsp_data;
               want_w   = expected;
               for (int k = 0; k < 5; k++) begin
                  if (got_w[4 - k] !== want_w[4 - k]) begin
                     flag_error($sformatf("word%0d_out got %h, expected %h",
                                          k, got_w[4 - k], want_w[4 - k]));
                  end
               end
            end
         end
         if (req_valid && req_ready) perm_expect_q.push_back(predict_perm(req_data));
         if (moved) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == STALL_LIMIT) begin
            $display("[%0t] watchdog: no beat moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("FAIL ascon_permutation_unit");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Stimulus sequence and end of run.
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // Directed part: zero rounds, every count, all-zero and all-one states,
      // alternating bits, and saturation of oversized counts.
      send_idle_pct = 21;
      recv_idle_pct = 68;
      perm_pending_q.push_back(make_req('0, '0, '0, '0, '0, 0));
      perm_pending_q.push_back(make_req(pick_word(), pick_word(), pick_word(),
                                        pick_word(), pick_word(), 0));
      for (int r = 1; r <= 16; r++) begin
         perm_pending_q.push_back(make_req({$urandom, $urandom}, {$urandom, $urandom},
                                           {$urandom, $urandom}, {$urandom, $urandom},
                                           {$urandom, $urandom}, r));
      end
      perm_pending_q.push_back(make_req('0, '0, '0, '0, '0, 16));
      perm_pending_q.push_back(make_req('1, '1, '1, '1, '1, 16));
      perm_pending_q.push_back(make_req({16{4'ha}}, {16{4'h5}}, {16{4'ha}},
                                        {16{4'h5}}, {16{4'ha}}, 12));
      perm_pending_q.push_back(make_req(pick_word(), pick_word(), pick_word(),
                                        pick_word(), pick_word(), 17));
      perm_pending_q.push_back(make_req('1, '0, '1, '0, '1, 31));

      // First random phase: sender idles a little, receiver a lot.
      queue_random(130);
      wait_drained();

      // Second phase: the other way round.
      send_idle_pct = 68;
      recv_idle_pct = 21;
      queue_random(130);
      wait_drained();

      // Third phase: no idling, but the receiver opens with a long hold-off
      // so that the unit backs up and stalls its request side.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_armed    = 1'b1;
      queue_random(140);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS ascon_permutation_unit");
      end else begin
         $display("FAIL ascon_permutation_unit");
      end
      $finish;
   end

endmodule
